[sv/csl_pkg.sv]
// Package for the cursor sequence list: default sizes, operation and status codes.
// Used by the channel interfaces and by the top, front and back modules; depends on nothing.
`default_nettype none

package csl_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_WIDTH       = 3;
    localparam int STATUS_WIDTH   = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_START   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ATTACH  = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_READ    = 3'd5
    } csl_op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NO_ITEM = 2'd2
    } csl_status_t;

endpackage

`default_nettype wire

[sv/csl_if.sv]
// Valid/ready channel interfaces for the cursor sequence list: command and response.
// Depends on csl_pkg for default widths.
`default_nettype none

interface csl_cmd_if #(
    parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [csl_pkg::OP_WIDTH-1:0]  op;
    logic [DATA_WIDTH-1:0]         entry_value;

    modport source (output valid, output op, output entry_value, input ready);
    modport sink   (input valid, input op, input entry_value, output ready);
endinterface

interface csl_rsp_if #(
    parameter int DATA_WIDTH  = csl_pkg::DATA_WIDTH_DEF,
    parameter int COUNT_WIDTH = $clog2(csl_pkg::CAPACITY_DEF + 1)
);
    logic                             valid;
    logic                             ready;
    logic [DATA_WIDTH-1:0]            current_value;
    logic                             has_item;
    logic [COUNT_WIDTH-1:0]           item_count;
    logic [csl_pkg::STATUS_WIDTH-1:0] status;

    modport source (output valid, output current_value, output has_item,
                    output item_count, output status, input ready);
    modport sink   (input valid, input current_value, input has_item,
                    input item_count, input status, output ready);
endinterface

`default_nettype wire

[sv/cursor_sequence_list.sv]
// Cursor sequence list: an ordered list of values with a cursor, kept as a singly
// linked list in a node pool with a free stack for removed nodes.
//
// The cmd channel carries one item per operation (op, entry_value); the rsp channel
// returns one item per command with the value at the cursor, whether the cursor is on
// an item, the count and a status. Both use valid/ready; an item moves on a rising
// edge with valid and ready high.
// A command enters a two-item queue in the front end. The back end takes each item
// through an execute state, which updates the list state, writes memory and issues a
// read, and then a finish state, which takes the registered read data, writes a second
// node link and loads the response register. Because of the registered read of the
// node memories, the back end takes a new item only as it finishes the last one.
// The response register lets the back end finish one item while the receiver stalls;
// with the register full, the back end holds its finished item and the queue fills,
// after which cmd.ready falls.
// Reset empties the list and the free stack at once; the node memories need no
// clearing pass, so commands are taken from the first cycle after reset.
// Depends on csl_pkg, csl_if, csl_ram, csl_front and csl_back.
`default_nettype none

module cursor_sequence_list #(
    parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    csl_cmd_if.sink  cmd,
    csl_rsp_if.source rsp
);

    logic                  task_valid;
    logic                  task_ready;
    csl_pkg::csl_op_t      task_op;
    logic [DATA_WIDTH-1:0] task_value;

    csl_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_op    (task_op),
        .task_value (task_value)
    );

    csl_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_op    (task_op),
        .task_value (task_value),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

[sv/csl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the node values, node links and free stack.
`default_nettype none

module csl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/csl_front.sv]
// Front end of the cursor sequence list: accepts command items, decodes the op code
// and holds up to two items for the back end. Depends on csl_pkg and csl_if.
`default_nettype none

module csl_front #(
    parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    csl_cmd_if.sink               cmd,
    output      logic             task_valid,
    input  wire logic             task_ready,
    output      csl_pkg::csl_op_t task_op,
    output      logic [DATA_WIDTH-1:0] task_value
);

    csl_pkg::csl_op_t      op_q_reg  [2];
    logic [DATA_WIDTH-1:0] val_q_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            fill_reg;
    csl_pkg::csl_op_t      op_dec;
    logic                  push;
    logic                  pop;

    // Unused op codes behave as a read.
    always_comb
    begin
        if (cmd.op > csl_pkg::OP_WIDTH'(csl_pkg::OP_READ))
        begin
            op_dec = csl_pkg::OP_READ;
        end
        else
        begin
            op_dec = csl_pkg::csl_op_t'(cmd.op);
        end
    end

    assign cmd.ready  = (fill_reg != 2'd2);
    assign task_valid = (fill_reg != 2'd0);
    assign task_op    = op_q_reg[rd_ptr_reg];
    assign task_value = val_q_reg[rd_ptr_reg];
    assign push       = cmd.valid && cmd.ready;
    assign pop        = task_valid && task_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg]  <= op_dec;
            val_q_reg[wr_ptr_reg] <= cmd.entry_value;
        end
    end

endmodule

`default_nettype wire

[sv/csl_back.sv]
// Back end of the cursor sequence list: list state, node memories, free stack and
// the response register. Depends on csl_pkg, csl_if and csl_ram.
`default_nettype none

module csl_back #(
    parameter int CAPACITY   = csl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  task_valid,
    output      logic                  task_ready,
    input  wire csl_pkg::csl_op_t      task_op,
    input  wire logic [DATA_WIDTH-1:0] task_value,
    csl_rsp_if.source                  rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] NONE    = IW'(CAPACITY);
    localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

    state_t                   state_reg,    state_next;
    csl_pkg::csl_op_t         op_reg,       op_next;
    logic [DATA_WIDTH-1:0]    val_reg,      val_next;
    logic [IW-1:0]            head_reg,     head_next;
    logic [IW-1:0]            tail_reg,     tail_next;
    logic [IW-1:0]            cur_reg,      cur_next;
    logic [IW-1:0]            prev_reg,     prev_next;
    logic [IW-1:0]            count_reg,    count_next;
    logic [IW-1:0]            free_top_reg, free_top_next;
    logic [IW-1:0]            fresh_reg,    fresh_next;
    logic [AW-1:0]            top_node_reg, top_node_next;
    logic [DATA_WIDTH-1:0]    cur_val_reg,  cur_val_next;
    logic [IW-1:0]            cur_lnk_reg,  cur_lnk_next;
    logic                     load_reg,     load_next;
    logic                     refill_reg,   refill_next;
    logic                     lnk_pend_reg, lnk_pend_next;
    logic [AW-1:0]            lnk_addr_reg, lnk_addr_next;
    logic [IW-1:0]            lnk_data_reg, lnk_data_next;
    csl_pkg::csl_status_t     status_reg,   status_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0]    out_value_reg, out_value_next;
    logic                     out_has_reg,   out_has_next;
    logic [IW-1:0]            out_count_reg, out_count_next;
    csl_pkg::csl_status_t     out_status_reg, out_status_next;

    logic                  vram_we;
    logic [AW-1:0]         vram_waddr;
    logic                  vram_re;
    logic [AW-1:0]         vram_raddr;
    logic [DATA_WIDTH-1:0] vram_rdata;
    logic                  nram_we;
    logic [AW-1:0]         nram_waddr;
    logic [IW-1:0]         nram_wdata;
    logic [IW-1:0]         nram_rdata;
    logic                  fram_we;
    logic [AW-1:0]         fram_waddr;
    logic                  fram_re;
    logic [AW-1:0]         fram_raddr;
    logic [AW-1:0]         fram_rdata;

    logic                  fin_go;
    logic                  take;
    logic                  item;
    logic                  full;
    logic [IW-1:0]         alloc_idx;
    logic [IW-1:0]         new_lnk;
    logic [IW-1:0]         ft_minus1;
    logic [IW-1:0]         ft_minus2;

    csl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (val_reg),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    csl_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (nram_we),
        .waddr (nram_waddr),
        .wdata (nram_wdata),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (nram_rdata)
    );

    csl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (fram_waddr),
        .wdata (cur_reg[AW-1:0]),
        .re    (fram_re),
        .raddr (fram_raddr),
        .rdata (fram_rdata)
    );

    assign item      = (cur_reg < CAP_IDX);
    assign full      = (count_reg >= CAP_IDX)
                    || ((free_top_reg == '0) && (fresh_reg >= CAP_IDX));
    assign ft_minus1 = free_top_reg - IW'(1);
    assign ft_minus2 = free_top_reg - IW'(2);
    assign alloc_idx = (free_top_reg != '0) ? IW'(top_node_reg) : fresh_reg;
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);
    assign task_ready = (state_reg == S_IDLE) || fin_go;
    assign take      = task_valid && task_ready;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        count_next      = count_reg;
        free_top_next   = free_top_reg;
        fresh_next      = fresh_reg;
        top_node_next   = top_node_reg;
        cur_val_next    = cur_val_reg;
        cur_lnk_next    = cur_lnk_reg;
        load_next       = load_reg;
        refill_next     = refill_reg;
        lnk_pend_next   = lnk_pend_reg;
        lnk_addr_next   = lnk_addr_reg;
        lnk_data_next   = lnk_data_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_has_next    = out_has_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        vram_we         = 1'b0;
        vram_waddr      = alloc_idx[AW-1:0];
        vram_re         = 1'b0;
        vram_raddr      = cur_lnk_reg[AW-1:0];
        nram_we         = 1'b0;
        nram_waddr      = alloc_idx[AW-1:0];
        nram_wdata      = NONE;
        fram_we         = 1'b0;
        fram_waddr      = free_top_reg[AW-1:0];
        fram_re         = 1'b0;
        fram_raddr      = ft_minus2[AW-1:0];
        new_lnk         = NONE;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            op_next    = task_op;
            val_next   = task_value;
            state_next = S_EXEC;
        end

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                state_next    = S_FIN;
                status_next   = csl_pkg::STAT_OK;
                load_next     = 1'b0;
                refill_next   = 1'b0;
                lnk_pend_next = 1'b0;
                unique case (op_reg)
                    csl_pkg::OP_START:
                    begin
                        if (count_reg != '0)
                        begin
                            cur_next   = head_reg;
                            prev_next  = NONE;
                            vram_re    = 1'b1;
                            vram_raddr = head_reg[AW-1:0];
                            load_next  = 1'b1;
                        end
                    end
                    csl_pkg::OP_ADVANCE:
                    begin
                        if (!item)
                        begin
                            status_next = csl_pkg::STAT_NO_ITEM;
                        end
                        else if (cur_reg == tail_reg)
                        begin
                            cur_next  = NONE;
                            prev_next = tail_reg;
                        end
                        else
                        begin
                            prev_next = cur_reg;
                            cur_next  = cur_lnk_reg;
                            vram_re   = 1'b1;
                            load_next = 1'b1;
                        end
                    end
                    csl_pkg::OP_INSERT, csl_pkg::OP_ATTACH:
                    begin
                        if (full)
                        begin
                            status_next = csl_pkg::STAT_FULL;
                        end
                        else
                        begin
                            if (free_top_reg != '0)
                            begin
                                free_top_next = ft_minus1;
                                if (free_top_reg >= IW'(2))
                                begin
                                    fram_re     = 1'b1;
                                    refill_next = 1'b1;
                                end
                            end
                            else
                            begin
                                fresh_next = fresh_reg + IW'(1);
                            end
                            if (count_reg == '0)
                            begin
                                head_next = alloc_idx;
                                tail_next = alloc_idx;
                                prev_next = NONE;
                            end
                            else if (op_reg == csl_pkg::OP_INSERT)
                            begin
                                if (!item || (cur_reg == head_reg))
                                begin
                                    new_lnk   = head_reg;
                                    head_next = alloc_idx;
                                    prev_next = NONE;
                                end
                                else
                                begin
                                    new_lnk       = cur_reg;
                                    lnk_pend_next = (prev_reg < CAP_IDX);
                                    lnk_addr_next = prev_reg[AW-1:0];
                                    lnk_data_next = alloc_idx;
                                end
                            end
                            else
                            begin
                                if (!item || (cur_reg == tail_reg))
                                begin
                                    lnk_pend_next = (tail_reg < CAP_IDX);
                                    lnk_addr_next = tail_reg[AW-1:0];
                                    lnk_data_next = alloc_idx;
                                    prev_next     = tail_reg;
                                    tail_next     = alloc_idx;
                                end
                                else
                                begin
                                    new_lnk       = cur_lnk_reg;
                                    lnk_pend_next = 1'b1;
                                    lnk_addr_next = cur_reg[AW-1:0];
                                    lnk_data_next = alloc_idx;
                                    prev_next     = cur_reg;
                                end
                            end
                            vram_we      = 1'b1;
                            nram_we      = 1'b1;
                            nram_wdata   = new_lnk;
                            cur_next     = alloc_idx;
                            cur_val_next = val_reg;
                            cur_lnk_next = new_lnk;
                            count_next   = count_reg + IW'(1);
                        end
                    end
                    csl_pkg::OP_REMOVE:
                    begin
                        if (!item)
                        begin
                            status_next = csl_pkg::STAT_NO_ITEM;
                        end
                        else
                        begin
                            if (count_reg <= IW'(1))
                            begin
                                cur_next  = NONE;
                                prev_next = NONE;
                                head_next = NONE;
                                tail_next = NONE;
                            end
                            else if (cur_reg == tail_reg)
                            begin
                                tail_next     = prev_reg;
                                lnk_pend_next = (prev_reg < CAP_IDX);
                                lnk_addr_next = prev_reg[AW-1:0];
                                lnk_data_next = NONE;
                                cur_next      = NONE;
                            end
                            else if (cur_reg == head_reg)
                            begin
                                head_next = cur_lnk_reg;
                                prev_next = NONE;
                                cur_next  = cur_lnk_reg;
                                vram_re   = 1'b1;
                                load_next = 1'b1;
                            end
                            else
                            begin
                                lnk_pend_next = (prev_reg < CAP_IDX);
                                lnk_addr_next = prev_reg[AW-1:0];
                                lnk_data_next = cur_lnk_reg;
                                cur_next      = cur_lnk_reg;
                                vram_re       = 1'b1;
                                load_next     = 1'b1;
                            end
                            if (free_top_reg < CAP_IDX)
                            begin
                                fram_we       = 1'b1;
                                top_node_next = cur_reg[AW-1:0];
                                free_top_next = free_top_reg + IW'(1);
                            end
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - IW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        if (!item)
                        begin
                            status_next = csl_pkg::STAT_NO_ITEM;
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    nram_we         = lnk_pend_reg;
                    nram_waddr      = lnk_addr_reg;
                    nram_wdata      = lnk_data_reg;
                    lnk_pend_next   = 1'b0;
                    if (load_reg)
                    begin
                        cur_val_next = vram_rdata;
                        cur_lnk_next = nram_rdata;
                    end
                    if (refill_reg)
                    begin
                        top_node_next = fram_rdata;
                    end
                    out_valid_next  = 1'b1;
                    out_has_next    = item;
                    out_value_next  = !item ? '0 : (load_reg ? vram_rdata : cur_val_reg);
                    out_count_next  = count_reg;
                    out_status_next = status_reg;
                    if (!take)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= csl_pkg::OP_READ;
            val_reg        <= '0;
            head_reg       <= NONE;
            tail_reg       <= NONE;
            cur_reg        <= NONE;
            prev_reg       <= NONE;
            count_reg      <= '0;
            free_top_reg   <= '0;
            fresh_reg      <= '0;
            top_node_reg   <= '0;
            cur_val_reg    <= '0;
            cur_lnk_reg    <= NONE;
            load_reg       <= 1'b0;
            refill_reg     <= 1'b0;
            lnk_pend_reg   <= 1'b0;
            lnk_addr_reg   <= '0;
            lnk_data_reg   <= NONE;
            status_reg     <= csl_pkg::STAT_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_has_reg    <= 1'b0;
            out_count_reg  <= '0;
            out_status_reg <= csl_pkg::STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            count_reg      <= count_next;
            free_top_reg   <= free_top_next;
            fresh_reg      <= fresh_next;
            top_node_reg   <= top_node_next;
            cur_val_reg    <= cur_val_next;
            cur_lnk_reg    <= cur_lnk_next;
            load_reg       <= load_next;
            refill_reg     <= refill_next;
            lnk_pend_reg   <= lnk_pend_next;
            lnk_addr_reg   <= lnk_addr_next;
            lnk_data_reg   <= lnk_data_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_has_reg    <= out_has_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.current_value = out_value_reg;
    assign rsp.has_item      = out_has_reg;
    assign rsp.item_count    = out_count_reg;
    assign rsp.status        = out_status_reg;

    a_exec_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_FIN)
        else $error("Execute cycle was not followed by the finish cycle.");

    a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {1'b0, free_top_reg}) == {1'b0, fresh_reg})
        else $error("Held nodes plus free nodes differ from nodes ever used.");

    a_full_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && status_reg == csl_pkg::STAT_FULL)
        |-> (op_reg == csl_pkg::OP_INSERT || op_reg == csl_pkg::OP_ATTACH))
        else $error("Pool full reported for an operation that takes no node.");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> (cur_reg == NONE && head_reg == NONE && tail_reg == NONE))
        else $error("Empty list still points at a node.");

endmodule

`default_nettype wire

[tb/sv/csl_list_checker.sv]
// Checker for the cursor sequence list: watches the command and response channels,
// keeps its own copy of the list and compares every response item with its prediction.
// Depends on csl_pkg and the channel interfaces in csl_if.
`timescale 1ns / 100ps

module csl_list_checker
    import csl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    csl_cmd_if        cmd,
    csl_rsp_if        rsp,
    output int        fail_count,
    output int        pending_count
);

    localparam int CAP = CAPACITY_DEF;
    localparam int NIL = CAPACITY_DEF;

    typedef struct {
        logic [DATA_WIDTH_DEF-1:0] value;
        logic                      on_item;
        logic [8:0]                count;
        csl_status_t               status;
    } list_view_t;

    logic [DATA_WIDTH_DEF-1:0] slot_val [CAP];
    int                        slot_link [CAP];
    int                        spare [CAP];
    int                        spare_top;
    int                        fresh_mark;
    int                        head;
    int                        tail;
    int                        cur;
    int                        prev;
    int                        held;
    list_view_t                predicted_views [$];
    list_view_t                want;

    function automatic int grab_slot(logic [DATA_WIDTH_DEF-1:0] v);
        int n;
        if (held >= CAP)
            return NIL;
        if (spare_top > 0)
        begin
            spare_top--;
            n = spare[spare_top];
        end
        else if (fresh_mark < CAP)
        begin
            n = fresh_mark;
            fresh_mark++;
        end
        else
            return NIL;
        slot_val[n]  = v;
        slot_link[n] = NIL;
        return n;
    endfunction

    function automatic list_view_t apply_list_op(logic [OP_WIDTH-1:0] op,
                                                 logic [DATA_WIDTH_DEF-1:0] v);
        list_view_t r;
        bit         on_item;
        int         n;
        r.status = STAT_OK;
        on_item  = (cur < CAP);
        case (op)
            OP_START:
            begin
                if (held > 0)
                begin
                    cur  = head;
                    prev = NIL;
                end
            end
            OP_ADVANCE:
            begin
                if (!on_item)
                    r.status = STAT_NO_ITEM;
                else if (cur == tail)
                begin
                    cur  = NIL;
                    prev = tail;
                end
                else
                begin
                    prev = cur;
                    cur  = slot_link[cur];
                end
            end
            OP_INSERT, OP_ATTACH:
            begin
                n = grab_slot(v);
                if (n == NIL)
                    r.status = STAT_FULL;
                else
                begin
                    if (held == 0)
                    begin
                        head = n;
                        tail = n;
                        prev = NIL;
                    end
                    else if (op == OP_INSERT)
                    begin
                        if (!on_item || cur == head)
                        begin
                            slot_link[n] = head;
                            head         = n;
                            prev         = NIL;
                        end
                        else
                        begin
                            slot_link[n] = cur;
                            if (prev < CAP)
                                slot_link[prev] = n;
                        end
                    end
                    else
                    begin
                        if (!on_item || cur == tail)
                        begin
                            if (tail < CAP)
                                slot_link[tail] = n;
                            prev = tail;
                            tail = n;
                        end
                        else
                        begin
                            slot_link[n]   = slot_link[cur];
                            slot_link[cur] = n;
                            prev           = cur;
                        end
                    end
                    cur = n;
                    held++;
                end
            end
            OP_REMOVE:
            begin
                if (!on_item)
                    r.status = STAT_NO_ITEM;
                else
                begin
                    n = cur;
                    if (held <= 1)
                    begin
                        cur  = NIL;
                        prev = NIL;
                        head = NIL;
                        tail = NIL;
                    end
                    else if (n == tail)
                    begin
                        tail = prev;
                        if (prev < CAP)
                            slot_link[prev] = NIL;
                        cur = NIL;
                    end
                    else if (n == head)
                    begin
                        head = slot_link[n];
                        prev = NIL;
                        cur  = head;
                    end
                    else
                    begin
                        if (prev < CAP)
                            slot_link[prev] = slot_link[n];
                        cur = slot_link[n];
                    end
                    if (spare_top < CAP)
                    begin
                        spare[spare_top] = n;
                        spare_top++;
                    end
                    if (held > 0)
                        held--;
                end
            end
            default:
            begin
                if (!on_item)
                    r.status = STAT_NO_ITEM;
            end
        endcase
        r.on_item = (cur < CAP);
        r.value   = r.on_item ? slot_val[cur] : '0;
        r.count   = 9'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spare_top  = 0;
            fresh_mark = 0;
            head       = NIL;
            tail       = NIL;
            cur        = NIL;
            prev       = NIL;
            held       = 0;
            fail_count = 0;
            predicted_views.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                predicted_views.push_back(apply_list_op(cmd.op, cmd.entry_value));
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_views.size() == 0)
                begin
                    $error("Response item arrived with no command outstanding.");
                    fail_count++;
                end
                else
                begin
                    want = predicted_views.pop_front();
                    if (rsp.current_value !== want.value)
                    begin
                        $error("current_value: expected %0h, got %0h",
                               want.value, rsp.current_value);
                        fail_count++;
                    end
                    if (rsp.has_item !== want.on_item)
                    begin
                        $error("has_item: expected %0d, got %0d", want.on_item, rsp.has_item);
                        fail_count++;
                    end
                    if (rsp.item_count !== want.count)
                    begin
                        $error("item_count: expected %0d, got %0d", want.count, rsp.item_count);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = predicted_views.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the cursor sequence list testbench: clock, reset, command stimulus and
// response back-pressure; the checker beside the block does all prediction.
// Depends on csl_pkg, csl_if, cursor_sequence_list and csl_list_checker.
`timescale 1ns / 100ps

module tb_top;
    import csl_pkg::*;

    localparam logic [OP_WIDTH-1:0] OP_SPARE_LO    = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_HI    = 3'd7;
    localparam int                  RANDOM_ITEMS   = 1500;
    localparam int                  WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   quiet;
    bit   calm;

    csl_cmd_if cmd_bus ();
    csl_rsp_if rsp_bus ();

    cursor_sequence_list u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    csl_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_bus),
        .rsp           (rsp_bus),
        .fail_count    (fails),
        .pending_count (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_WIDTH_DEF-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        return $urandom;
    endfunction

    // The mix leans toward growth, then toward draining, then stays balanced.
    function automatic logic [OP_WIDTH-1:0] pick_op(int idx);
        int r;
        r = $urandom_range(0, 99);
        if (idx < 500)
        begin
            if (r < 40) return OP_INSERT;
            if (r < 80) return OP_ATTACH;
            if (r < 85) return OP_REMOVE;
            if (r < 92) return OP_ADVANCE;
            if (r < 96) return OP_START;
            if (r < 98) return OP_READ;
            return (r == 98) ? OP_SPARE_LO : OP_SPARE_HI;
        end
        else if (idx < 950)
        begin
            if (r < 70) return OP_REMOVE;
            if (r < 85) return OP_START;
            if (r < 88) return OP_INSERT;
            if (r < 90) return OP_ATTACH;
            if (r < 95) return OP_ADVANCE;
            if (r < 98) return OP_READ;
            return (r == 98) ? OP_SPARE_LO : OP_SPARE_HI;
        end
        if (r < 20) return OP_INSERT;
        if (r < 40) return OP_ATTACH;
        if (r < 60) return OP_REMOVE;
        if (r < 75) return OP_ADVANCE;
        if (r < 85) return OP_START;
        if (r < 95) return OP_READ;
        return (r < 97) ? OP_SPARE_LO : OP_SPARE_HI;
    endfunction

    task automatic send_cmd(input logic [OP_WIDTH-1:0] op,
                            input logic [DATA_WIDTH_DEF-1:0] value);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.op          <= op;
        cmd_bus.entry_value <= value;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int busy;
        int gap;
        rsp_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            busy = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
            rsp_bus.ready <= 1'b1;
            repeat (busy) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        calm                = 1'b0;
        rst_n               <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.op          <= OP_READ;
        cmd_bus.entry_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list first: every cursor operation has no item to work on; then the list is built and cut down again.
        send_cmd(OP_READ, 32'h0000_0000);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_REMOVE, 32'h0000_0000);
        send_cmd(OP_START, 32'h0000_0000);
        send_cmd(OP_INSERT, 32'h0000_0000);
        send_cmd(OP_ATTACH, 32'hFFFF_FFFF);
        send_cmd(OP_START, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 32'h5555_5555);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_INSERT, 32'hAAAA_AAAA);
        send_cmd(OP_ATTACH, 32'h1234_5678);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_ATTACH, 32'h0000_0001);
        send_cmd(OP_REMOVE, 32'h0000_0000);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_INSERT, 32'h8000_0000);
        send_cmd(OP_ADVANCE, 32'h0000_0000);
        send_cmd(OP_REMOVE, 32'h0000_0000);
        send_cmd(OP_START, 32'h0000_0000);
        send_cmd(OP_REMOVE, 32'h0000_0000);
        send_cmd(OP_SPARE_LO, 32'hDEAD_BEEF);
        send_cmd(OP_SPARE_HI, 32'h0F0F_0F0F);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 1000 && i < 1150);
            send_cmd(pick_op(i), pick_value());
        end
        cmd_bus.valid <= 1'b0;

        // The checker records the last accepted item at that same edge.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
